// File: src/tla_pkg.sv
// ============================================================================
// tla_pkg: shared types and constants of the terminal line assembler
// Byte codes, field widths and the command passed from front to back.
// ============================================================================
package tla_pkg;

    // Field widths
    localparam int CHAN_W = 1;
    localparam int BYTE_W = 8;
    localparam int ECHO_W = 2;

    // Slot field of a command: wide enough for the largest line (256 bytes)
    localparam int SLOT_W = 8;

    // Default sizes
    localparam int DEF_CHANNELS   = 2;
    localparam int DEF_LINE_BYTES = 64;

    // Command queue depth (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [BYTE_W-1:0] BYTE_CR   = 8'd13;
    localparam logic [BYTE_W-1:0] BYTE_LF   = 8'd10;
    localparam logic [BYTE_W-1:0] BYTE_BEEP = 8'd7;
    localparam logic [BYTE_W-1:0] BYTE_NUL  = 8'd0;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // One classified received byte
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [BYTE_W-1:0] data;
        logic              line_end;  // drain the line instead of storing
        logic              echo;      // send the byte back to the transmitter
        logic              beep;      // line is full, send a beep
        logic [SLOT_W-1:0] slot;      // store slot, or fill count at line end
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: src/tla_in_if.sv
// ============================================================================
// tla_in_if: receive byte channel
// Valid/ready channel carrying one received character per beat.
// ============================================================================
interface tla_in_if;
    import tla_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] rx_byte;
    logic              tx_busy;

    modport source (output valid, output channel, output rx_byte, output tx_busy,
                    input ready);
    modport sink   (input valid, input channel, input rx_byte, input tx_busy,
                    output ready);
endinterface

// File: src/tla_out_if.sv
// ============================================================================
// tla_out_if: result channel
// Valid/ready channel carrying one echo, beep or line byte per beat.
// ============================================================================
interface tla_out_if;
    import tla_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_channel;
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;

    modport source (output valid, output out_channel, output kind, output data,
                    output last, input ready);
    modport sink   (input valid, input out_channel, input kind, input data,
                    input last, output ready);
endinterface

// File: src/tla_front.sv
// ============================================================================
// tla_front: byte classifier
// Accepts received bytes, tracks the fill index per channel and the echo
// register, and queues one command per live-channel byte for the back end.
// ============================================================================
module tla_front #(
    parameter int CHANNELS   = 2,
    parameter int LINE_BYTES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    tla_in_if.sink                    in_ch,
    input  logic                      cfg_wr_en,
    input  logic [tla_pkg::ECHO_W-1:0] cfg_wr_data,
    input  tla_pkg::q_status_t        q_stat,
    output logic                      push,
    output tla_pkg::cmd_t             cmd
);
    import tla_pkg::*;

    // Only channels 0 and 1 can be addressed by the channel field
    localparam int CH_LIVE   = (CHANNELS >= 2) ? 2 : 1;
    localparam int FILL_LIMIT = LINE_BYTES - 2;
    localparam int IDX_W     = $clog2(LINE_BYTES - 1);
    localparam logic [ECHO_W-1:0] ECHO_MASK = (CH_LIVE == 2) ? 2'b11 : 2'b01;

    logic [CH_LIVE-1:0][IDX_W-1:0] fill_reg, fill_next;
    logic [ECHO_W-1:0]             echo_reg, echo_next;

    logic             accept;
    logic             chan_ok;
    logic             is_eol;
    logic [IDX_W-1:0] fill_cur;
    logic [IDX_W:0]   fill_inc;
    logic             beep;
    logic [IDX_W-1:0] fill_adv;

    // Take a byte whenever the queue has room
    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign chan_ok     = (CH_LIVE == 2) || (in_ch.channel == '0);
    assign push        = accept && chan_ok;

    assign is_eol = (in_ch.rx_byte == BYTE_CR) || (in_ch.rx_byte == BYTE_LF);

    // Select the fill index of the addressed channel
    always_comb
    begin
        fill_cur = '0;
        for (int c = 0; c < CH_LIVE; c++)
        begin
            if (CHAN_W'(c) == in_ch.channel)
            begin
                fill_cur = fill_reg[c];
            end
        end
    end

    // Advance and saturate the fill index
    assign fill_inc = {1'b0, fill_cur} + 1'b1;
    assign beep     = !is_eol && (fill_inc >= (IDX_W + 1)'(FILL_LIMIT));
    assign fill_adv = beep ? IDX_W'(FILL_LIMIT) : fill_inc[IDX_W-1:0];

    always_comb
    begin
        fill_next = fill_reg;
        if (push)
        begin
            for (int c = 0; c < CH_LIVE; c++)
            begin
                if (CHAN_W'(c) == in_ch.channel)
                begin
                    fill_next[c] = is_eol ? '0 : fill_adv;
                end
            end
        end
    end

    // Echo register, unused channel bits dropped
    assign echo_next = cfg_wr_en ? (cfg_wr_data & ECHO_MASK) : echo_reg;

    // Build the command
    always_comb
    begin
        cmd.chan     = in_ch.channel;
        cmd.data     = in_ch.rx_byte;
        cmd.line_end = is_eol;
        cmd.echo     = echo_reg[in_ch.channel] && !in_ch.tx_busy;
        cmd.beep     = beep;
        cmd.slot     = SLOT_W'(fill_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            echo_reg <= ECHO_MASK;
        end
        else
        begin
            fill_reg <= fill_next;
            echo_reg <= echo_next;
        end
    end

endmodule

// File: src/tla_cmd_fifo.sv
// ============================================================================
// tla_cmd_fifo: command queue
// Short queue between classifier and sequencer so each side stalls alone.
// ============================================================================
module tla_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tla_pkg::cmd_t      cmd_in,
    input  logic               pop,
    output tla_pkg::cmd_t      cmd_out,
    output tla_pkg::q_status_t q_stat
);
    import tla_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    cmd_t          q_mem [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0]   cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == (QW + 1)'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign cmd_out      = q_mem[rd_ptr_reg];

    // Advance pointers and count; depth is a power of two so pointers wrap
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: src/tla_back.sv
// ============================================================================
// tla_back: line store and result sequencer
// Pops commands, writes bytes to the line store, and emits echo, beep and
// line beats through a registered output stage.
// ============================================================================
module tla_back #(
    parameter int CHANNELS   = 2,
    parameter int LINE_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tla_pkg::q_status_t q_stat,
    input  tla_pkg::cmd_t      cmd,
    output logic               pop,
    tla_out_if.source          out_ch
);
    import tla_pkg::*;

    localparam int CH_LIVE = (CHANNELS >= 2) ? 2 : 1;
    localparam int IDX_W   = $clog2(LINE_BYTES - 1);
    localparam int DEPTH   = CH_LIVE * LINE_BYTES;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ECHO = 3'd1;
    localparam logic [2:0] S_BEEP = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LINE = 3'd4;
    localparam logic [2:0] S_TERM = 3'd5;

    logic [2:0]        state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              ov_reg, ov_next;
    logic [CHAN_W-1:0] ochan_reg, ochan_next;
    logic              okind_reg, okind_next;
    logic [BYTE_W-1:0] odata_reg, odata_next;
    logic              olast_reg, olast_next;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    logic              can_load;
    logic              ld;
    logic              ld_kind;
    logic [BYTE_W-1:0] ld_data;
    logic              ld_last;
    logic [IDX_W-1:0]  idx_inc;

    assign pop      = (state_reg == S_IDLE) && !q_stat.empty;
    assign can_load = !ov_reg || out_ch.ready;
    assign idx_inc  = idx_reg + 1'b1;

    // Line store ports
    assign mem_we = pop && !cmd.line_end;
    assign mem_re = (state_reg == S_READ);
    assign waddr  = ADDR_W'(int'(cmd.chan) * LINE_BYTES + int'(IDX_W'(cmd.slot)));
    assign raddr  = ADDR_W'(int'(cur_reg.chan) * LINE_BYTES + int'(idx_reg));

    // Sequence the results of one command
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        ld         = 1'b0;
        ld_kind    = KIND_TX;
        ld_data    = cur_reg.data;
        ld_last    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    cur_next = cmd;
                    idx_next = '0;
                    if (cmd.echo)
                    begin
                        state_next = S_ECHO;
                    end
                    else if (cmd.line_end)
                    begin
                        state_next = (cmd.slot != '0) ? S_READ : S_TERM;
                    end
                    else if (cmd.beep)
                    begin
                        state_next = S_BEEP;
                    end
                end
            end
            S_ECHO:
            begin
                if (can_load)
                begin
                    ld      = 1'b1;
                    ld_last = !cur_reg.line_end && !cur_reg.beep;
                    if (cur_reg.line_end)
                    begin
                        state_next = (cur_reg.slot != '0) ? S_READ : S_TERM;
                    end
                    else
                    begin
                        state_next = cur_reg.beep ? S_BEEP : S_IDLE;
                    end
                end
            end
            S_BEEP:
            begin
                if (can_load)
                begin
                    ld         = 1'b1;
                    ld_data    = BYTE_BEEP;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_LINE;
            end
            S_LINE:
            begin
                if (can_load)
                begin
                    ld         = 1'b1;
                    ld_kind    = KIND_LINE;
                    ld_data    = rdata_reg;
                    idx_next   = idx_inc;
                    state_next = (idx_inc == IDX_W'(cur_reg.slot)) ? S_TERM : S_READ;
                end
            end
            S_TERM:
            begin
                if (can_load)
                begin
                    ld         = 1'b1;
                    ld_kind    = KIND_LINE;
                    ld_data    = BYTE_NUL;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load or drain the output stage
    always_comb
    begin
        ov_next    = ld ? 1'b1 : (out_ch.ready ? 1'b0 : ov_reg);
        ochan_next = ld ? cur_reg.chan : ochan_reg;
        okind_next = ld ? ld_kind : okind_reg;
        odata_next = ld ? ld_data : odata_reg;
        olast_next = ld ? ld_last : olast_reg;
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.out_channel = ochan_reg;
    assign out_ch.kind        = okind_reg;
    assign out_ch.data        = odata_reg;
    assign out_ch.last        = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        idx_reg   <= idx_next;
        ochan_reg <= ochan_next;
        okind_reg <= okind_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= cmd.data;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

// File: src/tty_line_assembler.sv
// ============================================================================
// tty_line_assembler: receive line assembler for a serial terminal
// Echoes received bytes, collects them per channel and emits whole lines.
// ============================================================================
// Usage:
//   in_ch  : one received byte per beat (channel, rx_byte, tx_busy).
//   out_ch : result beats (out_channel, kind, data, last); last marks the
//            final beat caused by one received byte.
//   cfg_wr_en / cfg_wr_data : write the echo enable bits, one per channel.
// A classifier takes bytes into a two-entry command queue; a sequencer
// drains it, writing the line store and producing beats into an output
// register. A byte reaches the output through the queue entry and the
// sequencer state; a line run without echo also passes the line store read.
// Ordinary byte: the sequencer pops it, then visits ECHO and BEEP as needed.
// Line end: pop, echo if on, READ then LINE per stored byte, TERM last;
// the line store read port, one registered read per byte, sets that pace.
// Input ready drops only while the queue is full.
// When out_ch stalls, the output register holds its beat and the sequencer
// waits; the queue keeps taking bytes until full.
// Reset clears the fill indexes and queue and sets echo on for all channels;
// the line store needs no clearing.
// ============================================================================
module tty_line_assembler #(
    parameter int CHANNELS   = tla_pkg::DEF_CHANNELS,
    parameter int LINE_BYTES = tla_pkg::DEF_LINE_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tla_in_if.sink                     in_ch,
    tla_out_if.source                  out_ch,
    input  logic                       cfg_wr_en,
    input  logic [tla_pkg::ECHO_W-1:0] cfg_wr_data
);
    import tla_pkg::*;

    logic      push;
    logic      pop;
    cmd_t      cmd_in;
    cmd_t      cmd_out;
    q_status_t q_stat;

    // Classify incoming bytes
    tla_front #(
        .CHANNELS   (CHANNELS),
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .push        (push),
        .cmd         (cmd_in)
    );

    // Buffer commands
    tla_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_in),
        .pop     (pop),
        .cmd_out (cmd_out),
        .q_stat  (q_stat)
    );

    // Execute commands
    tla_back #(
        .CHANNELS   (CHANNELS),
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .cmd    (cmd_out),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // Queue is never written while full nor read while empty
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command pushed into full queue");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // Queue status stays consistent
    a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    // Fill index never passes the saturation slot
    a_fill_limit: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cmd_in.slot <= SLOT_W'(LINE_BYTES - 2)))
        else $error("fill index beyond line limit");

endmodule

// File: test/tb_tty_line_assembler.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_tty_line_assembler: self-checking bench for the terminal line assembler
// Feeds received bytes on both channels through the valid/ready input,
// predicts every echo, beep and line beat, and checks each output beat in
// order. Covers all echo masks, empty and saturated lines, and output stalls.
// ============================================================================
module tb_tty_line_assembler;
    import tla_pkg::*;

    localparam int  CLK_PERIOD    = 10;
    localparam int  NUM_CHAN      = DEF_CHANNELS;
    localparam int  LINE_LEN      = DEF_LINE_BYTES;
    localparam int  FILL_LIMIT    = LINE_LEN - 2;
    localparam int  SETTLE_CYCLES = 24;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

    // ------------------------------------------------------------------------
    // Line assembly model: tracks per-channel line contents and queues the
    // beats each received byte should produce.
    // ------------------------------------------------------------------------
    class tty_line_model;
        logic [BYTE_W-1:0] line_buf [NUM_CHAN][LINE_LEN];
        int                fill_idx [NUM_CHAN];
        logic [ECHO_W-1:0] echo_mask;
        beat_t             pending_beats [$];
        int                mismatches;
        int                bytes_taken;
        int                beats_seen;
        int                lines_done;
        int                beeps_done;

        function new();
            foreach (line_buf[c, i])
                line_buf[c][i] = '0;
            foreach (fill_idx[c])
                fill_idx[c] = 0;
            echo_mask   = '1;
            mismatches  = 0;
            bytes_taken = 0;
            beats_seen  = 0;
            lines_done  = 0;
            beeps_done  = 0;
        endfunction

        function void queue_beat(logic [CHAN_W-1:0] ch, logic kind,
                                 logic [BYTE_W-1:0] data, logic last);
            beat_t b;
            b.chan = ch;
            b.kind = kind;
            b.data = data;
            b.last = last;
            pending_beats.push_back(b);
        endfunction

        // Predict the beats caused by one accepted byte
        function void take_byte(logic [CHAN_W-1:0] ch, logic [BYTE_W-1:0] rx,
                                logic busy);
            logic echo_on;
            logic beep;
            int   fill;
            echo_on = echo_mask[ch] && !busy;
            fill    = fill_idx[ch];
            bytes_taken++;
            if (rx == BYTE_CR || rx == BYTE_LF)
            begin
                // drain the line, then the terminator
                if (echo_on)
                    queue_beat(ch, KIND_TX, rx, 1'b0);
                for (int i = 0; i < fill; i++)
                    queue_beat(ch, KIND_LINE, line_buf[ch][i], 1'b0);
                queue_beat(ch, KIND_LINE, BYTE_NUL, 1'b1);
                fill_idx[ch] = 0;
                lines_done++;
            end
            else
            begin
                // store, advance and saturate at the last usable slot
                line_buf[ch][fill] = rx;
                fill++;
                beep = (fill >= FILL_LIMIT);
                if (beep)
                    fill = FILL_LIMIT;
                fill_idx[ch] = fill;
                if (echo_on)
                    queue_beat(ch, KIND_TX, rx, !beep);
                if (beep)
                begin
                    queue_beat(ch, KIND_TX, BYTE_BEEP, 1'b1);
                    beeps_done++;
                end
            end
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one output beat with the oldest expectation
        function void match_beat(logic [CHAN_W-1:0] ch, logic kind,
                                 logic [BYTE_W-1:0] data, logic last);
            beat_t want;
            beats_seen++;
            if ($isunknown({ch, kind, data, last}))
            begin
                $error("output beat carries unknown bits: ch %b kind %b data %b last %b",
                       ch, kind, data, last);
                mismatches++;
            end
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: ch %0d kind %0d data %0d last %0d",
                       ch, kind, data, last);
                mismatches++;
                return;
            end
            want = pending_beats.pop_front();
            check_field("out_channel", want.chan, ch);
            check_field("kind", want.kind, kind);
            check_field("data", want.data, data);
            check_field("last", want.last, last);
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [ECHO_W-1:0]   cfg_wr_data;

    tla_in_if  in_bus ();
    tla_out_if out_bus ();

    tty_line_model line_model;

    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;

    tty_line_assembler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_bus),
        .out_ch      (out_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock
    initial
        clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Output side: random back-pressure, or a long hold-off when requested
    initial
    begin : sink_side
        out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end
            else
                out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Check every output beat at the clock edge that accepts it
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
            line_model.match_beat(out_bus.out_channel, out_bus.kind,
                                  out_bus.data, out_bus.last);
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one byte and hold it until accepted; start and end at a falling edge
    task automatic send_byte(input logic [CHAN_W-1:0] ch, input logic [BYTE_W-1:0] rx,
                             input logic busy);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.channel <= ch;
        in_bus.rx_byte <= rx;
        in_bus.tx_busy <= busy;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        line_model.take_byte(ch, rx, busy);
        @(negedge clk);
    endtask

    // Drop valid, wait for all expected beats, then let the pipeline drain
    task automatic wait_quiet();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (line_model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_echo_mask(input logic [ECHO_W-1:0] mask);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mask;
        @(posedge clk);
        line_model.echo_mask = mask;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Ordinary byte, never a line end; zero and the beep code show up often
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        case ($urandom_range(19))
            0:       b = BYTE_NUL;
            1:       b = BYTE_BEEP;
            default:
            begin
                do
                    b = BYTE_W'($urandom_range(255));
                while (b == BYTE_CR || b == BYTE_LF);
            end
        endcase
        return b;
    endfunction

    // Mostly short lines, now and then one long enough to saturate
    function automatic int pick_length();
        if ($urandom_range(99) < 12)
            return $urandom_range(FILL_LIMIT + 13, FILL_LIMIT - 4);
        return $urandom_range(12, 0);
    endfunction

    // Well-formed lines with random content, interleaved across channels,
    // with some stray bytes and lines cut short
    task automatic random_items(input int count);
        int                want_len [NUM_CHAN];
        int                have_len [NUM_CHAN];
        logic [CHAN_W-1:0] ch;
        logic [BYTE_W-1:0] b;
        ch = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            want_len[c] = pick_length();
            have_len[c] = 0;
        end
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 20)
                ch = CHAN_W'($urandom_range(NUM_CHAN - 1));
            if (have_len[ch] >= want_len[ch])
            begin
                b = $urandom_range(1) ? BYTE_CR : BYTE_LF;
                have_len[ch] = 0;
                want_len[ch] = pick_length();
            end
            else if ($urandom_range(99) < 6)
            begin
                // noise: any byte at all, or a line end that comes early
                b = $urandom_range(1) ? BYTE_CR : BYTE_W'($urandom_range(255));
                if (b == BYTE_CR || b == BYTE_LF)
                    have_len[ch] = 0;
                else
                    have_len[ch]++;
            end
            else
            begin
                b = plain_byte();
                have_len[ch]++;
            end
            send_byte(ch, b, $urandom_range(99) < 30);
        end
    endtask

    // Main sequence
    initial
    begin : main_seq
        line_model   = new();
        src_idle_pct = 16;
        snk_idle_pct = 60;
        hold_left    = 0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_bus.valid   = 1'b0;
        in_bus.channel = '0;
        in_bus.rx_byte = '0;
        in_bus.tx_busy = 1'b0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty lines, zero byte in a line, byte extremes, echo on
        send_byte(1'b0, BYTE_CR, 1'b0);
        send_byte(1'b1, BYTE_LF, 1'b1);
        send_byte(1'b0, BYTE_NUL, 1'b0);
        send_byte(1'b0, 8'hFF, 1'b1);
        send_byte(1'b0, BYTE_BEEP, 1'b0);
        send_byte(1'b1, 8'h41, 1'b0);
        send_byte(1'b1, 8'h80, 1'b1);
        send_byte(1'b1, 8'h7F, 1'b0);
        send_byte(1'b0, BYTE_LF, 1'b0);
        send_byte(1'b1, BYTE_CR, 1'b1);
        wait_quiet();

        // Directed with echo off: stored bytes give nothing until line end
        write_echo_mask(2'b00);
        send_byte(1'b0, 8'h55, 1'b0);
        send_byte(1'b0, 8'hAA, 1'b1);
        send_byte(1'b1, 8'h01, 1'b0);
        send_byte(1'b0, BYTE_CR, 1'b0);
        send_byte(1'b1, BYTE_LF, 1'b0);
        random_items(140);
        wait_quiet();

        // Sender idles often, receiver rarely
        src_idle_pct = 60;
        snk_idle_pct = 16;
        write_echo_mask(2'b01);
        random_items(140);
        wait_quiet();

        // No idling; hold the output off long enough to fill the block
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_echo_mask(2'b11);
        hold_left = HOLD_CYCLES;
        random_items(70);
        wait_quiet();

        write_echo_mask(2'b10);
        random_items(70);
        wait_quiet();

        $display("Sent %0d bytes, checked %0d beats: %0d lines, %0d beeps.",
                 line_model.bytes_taken, line_model.beats_seen,
                 line_model.lines_done, line_model.beeps_done);
        $display("Echo masks 00/01/10/11, both-side idling and a long output hold-off.");
        if (line_model.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
